// ===== hdl/gdcsc_pkg.sv =====
// Shared codes and field widths for the grid difference CSC column generator.
// No dependencies; imported by the top level.
package gdcsc_pkg;

   // Configuration port layout
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int SIZE_W      = 9;
   localparam int AXIS_W      = 2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_SEL    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANT_SEL = 3'd4;

   // Difference direction codes
   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // Entry values
   localparam logic signed [1:0] VAL_NONE = 2'sb00;
   localparam logic signed [1:0] VAL_POS  = 2'sb01;
   localparam logic signed [1:0] VAL_NEG  = 2'sb11;

endpackage

// ===== hdl/gdcsc_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Standalone; the divisor must stay stable while items are in flight.
module gdcsc_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 9,
   parameter int SIDE_W     = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [DIVIDEND_W-1:0] out_quotient,
   output logic [DIVISOR_W-1:0]  out_remainder,
   output logic [SIDE_W-1:0]     out_side
);

   logic [DIVIDEND_W-1:0] vld_ff;
   logic [DIVISOR_W-1:0]  rem_ff   [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] work_ff  [DIVIDEND_W];
   logic [SIDE_W-1:0]     side_ff  [DIVIDEND_W];
   logic [DIVISOR_W-1:0]  rem_src  [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] work_src [DIVIDEND_W];
   logic [DIVISOR_W-1:0]  rem_in   [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] work_in  [DIVIDEND_W];

   // Each stage shifts in the next dividend bit and subtracts when it fits.
   always_comb begin
      logic [DIVISOR_W:0] trial;
      logic               fits;
      rem_src[0]  = '0;
      work_src[0] = in_dividend;
      for (int st = 1; st < DIVIDEND_W; st++) begin
         rem_src[st]  = rem_ff[st-1];
         work_src[st] = work_ff[st-1];
      end
      for (int st = 0; st < DIVIDEND_W; st++) begin
         trial = {rem_src[st], work_src[st][DIVIDEND_W-1]};
         fits  = trial >= {1'b0, divisor};
         if (fits) begin
            rem_in[st] = DIVISOR_W'(trial - {1'b0, divisor});
         end else begin
            rem_in[st] = trial[DIVISOR_W-1:0];
         end
         work_in[st] = {work_src[st][DIVIDEND_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIVIDEND_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int st = 1; st < DIVIDEND_W; st++) begin
         side_ff[st] <= side_ff[st-1];
      end
      for (int st = 0; st < DIVIDEND_W; st++) begin
         rem_ff[st]  <= rem_in[st];
         work_ff[st] <= work_in[st];
      end
   end

   assign out_valid     = vld_ff[DIVIDEND_W-1];
   assign out_quotient  = work_ff[DIVIDEND_W-1];
   assign out_remainder = rem_ff[DIVIDEND_W-1];
   assign out_side      = side_ff[DIVIDEND_W-1];

endmodule

// ===== hdl/grid_difference_csc_column_gen.sv =====
// Top level of the grid difference CSC column generator.
// Depends on gdcsc_pkg and gdcsc_div.
//
//   channel   ports                                  transfer
//   --------  -------------------------------------  ------------------------------
//   request   start, busy, req_column                start high while busy low
//   response  rsp_strobe, rsp_entry_count ..         one cycle per strobe, no stall
//             rsp_column_end
//   config    csr_valid, csr_ready, csr_index,       csr_valid and csr_ready high
//             csr_data
//
// Cycles: one column per clock. The depth is set by the two shift-subtract dividers
// (column by size_x, then by size_y), one quotient bit per stage, followed by five
// stages of select, multiply and add.
// Reset: synchronous; clears valid bits and the configuration registers. Derived
// configuration constants (strides, per-line counts, total) refresh every cycle and
// settle after a write, well before any item needs them.
// Stalls: none; the receiver takes every strobe, so the pipeline never stops.
module grid_difference_csc_column_gen #(
   parameter int MAX_DIM    = 256,
   parameter int INDEX_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [INDEX_BITS-1:0]               req_column,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_entry_count,
   output logic [INDEX_BITS-1:0]               rsp_first_row,
   output logic signed [1:0]                   rsp_first_value,
   output logic [INDEX_BITS-1:0]               rsp_second_row,
   output logic signed [1:0]                   rsp_second_value,
   output logic [INDEX_BITS:0]                 rsp_column_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gdcsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gdcsc_pkg::CSR_DATA_W-1:0]    csr_data
);

   import gdcsc_pkg::*;

   localparam int SIZE_MAX = (1 << SIZE_W) - 1;
   localparam int DIM_CAP  = (MAX_DIM < SIZE_MAX) ? MAX_DIM : SIZE_MAX;
   localparam int DW       = $clog2(DIM_CAP + 1);     // clamped size width
   localparam int SW       = 2 * DW;                  // stride / plane width
   localparam int IW       = INDEX_BITS;
   localparam int EW       = INDEX_BITS + 1;          // end pointer width
   localparam int KW       = (IW > DW) ? IW : DW;
   localparam int SIDE2_W  = 2 * IW + DW;
   localparam int LATENCY  = 2 * INDEX_BITS + 5;

   // Map a written size to the range 1..MAX_DIM.
   function automatic logic [DW-1:0] clamp_dim(input logic [SIZE_W-1:0] raw);
      if (raw == '0) begin
         return DW'(1);
      end
      if (32'(raw) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end
      return DW'(raw);
   endfunction

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [DW-1:0]     nx_ff, ny_ff, nz_ff;
   logic [AXIS_W-1:0] axis_ff;
   logic              sq_ff;

   assign csr_ready = 1'b1;
   // Hold off transfers while reset is applied.
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff   <= DW'(1);
         ny_ff   <= DW'(1);
         nz_ff   <= DW'(1);
         axis_ff <= AXIS_X;
         sq_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIZE_X:      nx_ff   <= clamp_dim(csr_data[SIZE_W-1:0]);
            CSR_SIZE_Y:      ny_ff   <= clamp_dim(csr_data[SIZE_W-1:0]);
            CSR_SIZE_Z:      nz_ff   <= clamp_dim(csr_data[SIZE_W-1:0]);
            CSR_AXIS_SEL:    axis_ff <= csr_data[AXIS_W-1:0];
            CSR_VARIANT_SEL: sq_ff   <= csr_data[0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Derived configuration constants, recomputed every cycle in four steps
   // ---------------------------------------------------------------------------
   logic [SW-1:0] nh_ff, nyz_ff;
   logic [SW-1:0] s_in, s_ff, blocks_in, blocks_ff;
   logic [DW-1:0] na_in, na_ff, na1_ff;
   logic [DW:0]   m_in, m_ff;
   logic [EW-1:0] pb_ff, sm_ff, total_ff;

   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            s_in      = SW'(1);
            na_in     = nx_ff;
            blocks_in = nyz_ff;
         end
         AXIS_Y: begin
            s_in      = SW'(nx_ff);
            na_in     = ny_ff;
            blocks_in = SW'(nz_ff);
         end
         default: begin
            s_in      = nh_ff;
            na_in     = nz_ff;
            blocks_in = SW'(1);
         end
      endcase
      // entries per cell line: 2*na-1 when square, 2*(na-1) with boundary rows dropped
      if (sq_ff) begin
         m_in = {na_in, 1'b0} - (DW + 1)'(1);
      end else begin
         m_in = {na_in - DW'(1), 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      nh_ff     <= SW'(nx_ff) * SW'(ny_ff);
      nyz_ff    <= SW'(ny_ff) * SW'(nz_ff);
      s_ff      <= s_in;
      na_ff     <= na_in;
      na1_ff    <= na_in - DW'(1);
      blocks_ff <= blocks_in;
      m_ff      <= m_in;
      pb_ff     <= EW'(s_ff) * EW'(m_ff);
      sm_ff     <= EW'(s_ff) * EW'(na1_ff);
      total_ff  <= EW'(blocks_ff) * pb_ff;
   end

   // ---------------------------------------------------------------------------
   // Coordinate split: column = i + nx*t, t = j + ny*k
   // ---------------------------------------------------------------------------
   logic               d1_valid;
   logic [IW-1:0]      d1_quot;
   logic [DW-1:0]      d1_rem;
   logic [IW-1:0]      d1_side;
   logic               d2_valid;
   logic [IW-1:0]      d2_quot;
   logic [DW-1:0]      d2_rem;
   logic [SIDE2_W-1:0] d2_side;
   logic [IW-1:0]      d2_col, d2_t;
   logic [DW-1:0]      d2_i;

   gdcsc_div #(
      .DIVIDEND_W (IW),
      .DIVISOR_W  (DW),
      .SIDE_W     (IW)
   ) u_div_x (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .in_dividend   (req_column),
      .divisor       (nx_ff),
      .in_side       (req_column),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem),
      .out_side      (d1_side)
   );

   gdcsc_div #(
      .DIVIDEND_W (IW),
      .DIVISOR_W  (DW),
      .SIDE_W     (SIDE2_W)
   ) u_div_y (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_dividend   (d1_quot),
      .divisor       (ny_ff),
      .in_side       ({d1_side, d1_rem, d1_quot}),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem),
      .out_side      (d2_side)
   );

   assign d2_col = d2_side[SIDE2_W-1 -: IW];
   assign d2_i   = d2_side[IW +: DW];
   assign d2_t   = d2_side[IW-1:0];

   // ---------------------------------------------------------------------------
   // Stage 1: plane offset j*nx and the out-of-grid check
   // ---------------------------------------------------------------------------
   logic          p1_vld_ff;
   logic [IW-1:0] p1_col_ff, p1_k_ff, p1_t_ff;
   logic [DW-1:0] p1_i_ff, p1_j_ff;
   logic [SW-1:0] p1_jnx_ff;
   logic          p1_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_col_ff <= d2_col;
      p1_i_ff   <= d2_i;
      p1_j_ff   <= d2_rem;
      p1_k_ff   <= d2_quot;
      p1_t_ff   <= d2_t;
      p1_jnx_ff <= SW'(d2_rem) * SW'(nx_ff);
      p1_out_ff <= KW'(d2_quot) >= KW'(nz_ff);
   end

   // ---------------------------------------------------------------------------
   // Stage 2: pick offset within line (lo), position on axis (a), line block (hi)
   // ---------------------------------------------------------------------------
   logic          p2_vld_ff;
   logic [IW-1:0] p2_col_ff, p2_hi_ff;
   logic [SW-1:0] p2_lo_ff;
   logic [DW-1:0] p2_a_ff;
   logic          p2_first_ff, p2_last_ff, p2_out_ff;
   logic [SW-1:0] lo_in;
   logic [DW-1:0] a_in;
   logic [IW-1:0] hi_in;

   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            lo_in = '0;
            a_in  = p1_i_ff;
            hi_in = p1_t_ff;
         end
         AXIS_Y: begin
            lo_in = SW'(p1_i_ff);
            a_in  = p1_j_ff;
            hi_in = p1_k_ff;
         end
         default: begin
            lo_in = SW'(p1_i_ff) + p1_jnx_ff;
            a_in  = DW'(p1_k_ff);
            hi_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_col_ff   <= p1_col_ff;
      p2_lo_ff    <= lo_in;
      p2_a_ff     <= a_in;
      p2_hi_ff    <= hi_in;
      p2_first_ff <= a_in != '0;
      p2_last_ff  <= ((DW + 1)'(a_in) + (DW + 1)'(1)) < {1'b0, na_ff};
      p2_out_ff   <= p1_out_ff;
   end

   // ---------------------------------------------------------------------------
   // Stage 3: products with the stride and per-block counts
   // ---------------------------------------------------------------------------
   logic          p3_vld_ff;
   logic [IW-1:0] p3_col_ff;
   logic [SW-1:0] p3_lo_ff;
   logic          p3_first_ff, p3_last_ff, p3_out_ff;
   logic [EW-1:0] p3_hp_ff, p3_hr_ff, p3_as_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_col_ff   <= p2_col_ff;
      p3_lo_ff    <= p2_lo_ff;
      p3_first_ff <= p2_first_ff;
      p3_last_ff  <= p2_last_ff;
      p3_out_ff   <= p2_out_ff;
      p3_hp_ff    <= EW'(p2_hi_ff) * pb_ff;
      p3_hr_ff    <= EW'(p2_hi_ff) * sm_ff;
      p3_as_ff    <= EW'(p2_a_ff) * EW'(s_ff);
   end

   // ---------------------------------------------------------------------------
   // Stage 4: column start base, row r of the pair, lo times entries per cell
   // ---------------------------------------------------------------------------
   logic          p4_vld_ff;
   logic [IW-1:0] p4_col_ff, p4_r_ff;
   logic          p4_first_ff, p4_last_ff, p4_out_ff;
   logic [EW-1:0] p4_base_ff, p4_lc_ff;
   logic [EW-1:0] as2, inner, base_in, r_in, lc_in;
   logic [1:0]    cell_cnt;

   always_comb begin
      as2 = p3_as_ff << 1;
      if (sq_ff) begin
         inner    = as2;
         cell_cnt = p3_last_ff ? 2'd2 : 2'd1;
      end else begin
         // entries before this cell on its line: 2a-1 with a left neighbor, else none
         inner    = p3_first_ff ? (as2 - EW'(s_ff)) : '0;
         cell_cnt = {1'b0, p3_first_ff} + {1'b0, p3_last_ff};
      end
      base_in = p3_hp_ff + inner;
      r_in    = EW'(p3_lo_ff) + p3_as_ff + p3_hr_ff;
      case (cell_cnt)
         2'd1:    lc_in = EW'(p3_lo_ff);
         2'd2:    lc_in = EW'(p3_lo_ff) << 1;
         default: lc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_col_ff   <= p3_col_ff;
      p4_first_ff <= p3_first_ff;
      p4_last_ff  <= p3_last_ff;
      p4_out_ff   <= p3_out_ff;
      p4_base_ff  <= base_in;
      p4_r_ff     <= r_in[IW-1:0];
      p4_lc_ff    <= lc_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 5: assemble the entries and the end pointer into the output register
   // ---------------------------------------------------------------------------
   logic                 out_vld_ff;
   logic [1:0]           out_cnt_ff, cnt_in;
   logic [IW-1:0]        out_row0_ff, out_row1_ff, row0_in, row1_in;
   logic signed [1:0]    out_val0_ff, out_val1_ff, val0_in, val1_in;
   logic [EW-1:0]        out_end_ff, end_in;

   always_comb begin
      cnt_in  = 2'd0;
      row0_in = '0;
      val0_in = VAL_NONE;
      row1_in = '0;
      val1_in = VAL_NONE;
      end_in  = '0;
      case (axis_ff) inside
         AXIS_X, AXIS_Y, AXIS_Z: begin
            if (p4_out_ff) begin
               end_in = total_ff;
            end else if (sq_ff) begin
               // diagonal first, then the neighbor further along the axis
               cnt_in  = p4_last_ff ? 2'd2 : 2'd1;
               row0_in = p4_col_ff;
               val0_in = VAL_POS;
               if (p4_last_ff) begin
                  row1_in = p4_col_ff + IW'(s_ff);
                  val1_in = VAL_NEG;
               end
               end_in = p4_base_ff + p4_lc_ff + EW'(cnt_in);
            end else begin
               cnt_in = {1'b0, p4_first_ff} + {1'b0, p4_last_ff};
               if (p4_first_ff) begin
                  row0_in = p4_r_ff - IW'(s_ff);
                  val0_in = VAL_POS;
                  if (p4_last_ff) begin
                     row1_in = p4_r_ff;
                     val1_in = VAL_NEG;
                  end
               end else if (p4_last_ff) begin
                  row0_in = p4_r_ff;
                  val0_in = VAL_NEG;
               end
               end_in = p4_base_ff + p4_lc_ff + EW'(cnt_in);
            end
         end
         default: begin
            // unused axis code: empty column, end pointer zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_cnt_ff  <= cnt_in;
      out_row0_ff <= row0_in;
      out_val0_ff <= val0_in;
      out_row1_ff <= row1_in;
      out_val1_ff <= val1_in;
      out_end_ff  <= end_in;
   end

   assign rsp_strobe       = out_vld_ff;
   assign rsp_entry_count  = out_cnt_ff;
   assign rsp_first_row    = out_row0_ff;
   assign rsp_first_value  = out_val0_ff;
   assign rsp_second_row   = out_row1_ff;
   assign rsp_second_value = out_val1_ff;
   assign rsp_column_end   = out_end_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // Every transfer comes out as a strobe at the end of the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("transfer did not produce a result on time");

   // No result without a matching earlier transfer.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transfer");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entry_count != 2'd3)
      else $error("entry count out of range");

   // An unused second entry reads as zero.
   a_unused: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_count != 2'd2) |->
         (rsp_second_row == '0 && rsp_second_value == VAL_NONE))
      else $error("second entry not cleared");

endmodule
